/* rtl/core/pfb_pkg.sv */
// Shared types, constants and the built-in 5x7 column font of the page framebuffer renderer.
package pfb_pkg;

    localparam int GLYPH_WIDTH  = 5;
    localparam int GLYPH_HEIGHT = 7;

    localparam logic [7:0] CODE_LOW  = 8'd32;
    localparam logic [7:0] CODE_HIGH = 8'd90;

    typedef enum logic [1:0] {
        ACT_PIXEL = 2'd0,
        ACT_CHAR  = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_PIXEL,
        KIND_CHAR,
        KIND_FILL,
        KIND_READ,
        KIND_OK,
        KIND_BAD
    } cmd_kind_t;

    // Column 0 is the leftmost byte; bit r of a byte is glyph row r.
    typedef logic [0:GLYPH_WIDTH-1][7:0] glyph_t;

    typedef struct packed {
        logic [8:0] width;
        logic [3:0] pages;
    } geom_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       on;
        logic [7:0] px;
        logic [7:0] py;
        logic [2:0] page;
        glyph_t     glyph;
        logic [7:0] pattern;
    } cmd_t;

    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        glyph_t g;
        case (code)
            8'd45:   g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08}; // -
            8'd46:   g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00}; // .
            8'd47:   g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02}; // /
            8'd48:   g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}; // 0
            8'd49:   g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            8'd50:   g = {8'h62, 8'h51, 8'h49, 8'h49, 8'h46};
            8'd51:   g = {8'h22, 8'h49, 8'h49, 8'h49, 8'h36};
            8'd52:   g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            8'd53:   g = {8'h2F, 8'h49, 8'h49, 8'h49, 8'h31};
            8'd54:   g = {8'h3E, 8'h49, 8'h49, 8'h49, 8'h32};
            8'd55:   g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            8'd56:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'd57:   g = {8'h26, 8'h49, 8'h49, 8'h49, 8'h3E}; // 9
            8'd58:   g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00}; // :
            8'd61:   g = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14}; // =
            8'd65:   g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}; // A
            8'd66:   g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            8'd67:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            8'd68:   g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            8'd69:   g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            8'd70:   g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            8'd71:   g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            8'd72:   g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'd73:   g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'd74:   g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
            8'd75:   g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            8'd76:   g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            8'd77:   g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            8'd78:   g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            8'd79:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'd80:   g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            8'd81:   g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
            8'd82:   g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            8'd83:   g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            8'd84:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'd85:   g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'd86:   g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'd87:   g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
            8'd88:   g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            8'd89:   g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            8'd90:   g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43}; // Z
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

/* rtl/core/pfb_ram.sv */
// Generic single-port RAM with registered read data.
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

/* rtl/core/pfb_fifo.sv */
// Small synchronous queue between the command front end and the execution back end.
module pfb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/pfb_front.sv */
// Front end: takes input beats, checks bounds, looks up the glyph and queues a command.
module pfb_front (
    input  logic          clear_busy,
    input  pfb_pkg::geom_t geom,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_action,
    input  logic [7:0]    s_pos_x,
    input  logic [7:0]    s_pos_y,
    input  logic [2:0]    s_read_page,
    input  logic [7:0]    s_char_code,
    input  logic          s_pixel_on,
    input  logic [7:0]    s_fill_pattern,
    input  logic          queue_full,
    output logic          push,
    output pfb_pkg::cmd_t push_cmd
);
    import pfb_pkg::*;

    logic [7:0] rows;
    logic       x_out, y_out, page_out, code_ok;

    assign rows     = 8'({geom.pages, 3'b000});
    assign x_out    = ({1'b0, s_pos_x} >= geom.width);
    assign y_out    = (s_pos_y >= rows);
    assign page_out = ({1'b0, s_read_page} >= geom.pages);
    assign code_ok  = s_char_code inside {[CODE_LOW:CODE_HIGH]};

    assign s_ready = !queue_full && !clear_busy;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_cmd.kind    = KIND_OK;
        push_cmd.on      = s_pixel_on;
        push_cmd.px      = s_pos_x;
        push_cmd.py      = s_pos_y;
        push_cmd.page    = s_pos_y[5:3];
        push_cmd.glyph   = glyph_lookup(s_char_code);
        push_cmd.pattern = s_fill_pattern;
        case (action_t'(s_action))
            ACT_PIXEL: begin
                push_cmd.kind = (x_out || y_out) ? KIND_BAD : KIND_PIXEL;
            end
            ACT_CHAR: begin
                // codes outside the font draw nothing but still answer ok
                push_cmd.kind = code_ok ? KIND_CHAR : KIND_OK;
            end
            ACT_FILL: begin
                push_cmd.kind = KIND_FILL;
            end
            ACT_READ: begin
                push_cmd.kind = (x_out || page_out) ? KIND_BAD : KIND_READ;
                push_cmd.page = s_read_page;
            end
            default: begin
                push_cmd.kind = KIND_OK;
            end
        endcase
    end

endmodule

/* rtl/core/pfb_back.sv */
// Back end: executes queued commands against the frame store and holds the result register.
module pfb_back #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_PAGES   = 8
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  pfb_pkg::geom_t                               geom,
    output logic                                         clear_busy,
    input  logic                                         q_valid,
    input  pfb_pkg::cmd_t                                q_cmd,
    output logic                                         q_pop,
    output logic                                         ram_we,
    output logic [$clog2(MAX_COLUMNS * MAX_PAGES)-1:0]   ram_addr,
    output logic [7:0]                                   ram_wdata,
    input  logic [7:0]                                   ram_rdata,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic                                         m_status,
    output logic [7:0]                                   m_read_data
);
    import pfb_pkg::*;

    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_PAGES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PIXEL,
        S_READ_ADDR,
        S_READ_DATA,
        S_GLYPH,
        S_WRITE,
        S_FILL,
        S_DONE
    } state_t;

    state_t            state_reg, adv_state;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  idx_reg, fill_cnt;
    logic [2:0]        col_reg, col_next;
    logic              slot_reg, slot_next;
    logic [ADDR_W-1:0] addr_reg, calc_addr;
    logic [7:0]        mask_reg;
    logic              res_status_reg;
    logic [7:0]        res_data_reg;
    logic              m_valid_reg, m_status_reg;
    logic [7:0]        m_read_data_reg;

    logic [7:0]  rows, col_bits, gx, gy, py_end, gmask, pix_mask;
    logic [4:0]  page_a, page_b, gpage;
    logic        gskip;
    logic [2:0]  calc_page;
    logic [7:0]  calc_col;

    assign clear_busy  = (state_reg == S_CLEAR);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_read_data = m_read_data_reg;

    assign rows     = 8'({geom.pages, 3'b000});
    assign fill_cnt = CNT_W'(geom.width) * CNT_W'(geom.pages);
    assign pix_mask = 8'd1 << cmd_reg.py[2:0];

    // Glyph column under work: which pixels of the chosen page it lights.
    always_comb begin
        col_bits = cmd_reg.glyph[col_reg];
        gx       = cmd_reg.px + 8'(col_reg);
        py_end   = cmd_reg.py + 8'(GLYPH_HEIGHT - 1);
        page_a   = cmd_reg.py[7:3];
        page_b   = py_end[7:3];
        gpage    = slot_reg ? page_b : page_a;
        gmask    = '0;
        gy       = '0;
        for (int r = 0; r < GLYPH_HEIGHT; r++) begin
            gy = cmd_reg.py + 8'(r);
            if (col_bits[r] && (gy < rows) && (gy[7:3] == gpage)) begin
                gmask[gy[2:0]] = 1'b1;
            end
        end
        if (slot_reg && (page_a == page_b)) begin
            gmask = '0;
        end
        gskip = (gmask == '0) || ({1'b0, gx} >= geom.width);
    end

    // Step to the next page slot or column of the glyph.
    always_comb begin
        adv_state = S_GLYPH;
        col_next  = col_reg;
        slot_next = ~slot_reg;
        if (slot_reg) begin
            if (col_reg == 3'(GLYPH_WIDTH - 1)) begin
                adv_state = S_DONE;
            end else begin
                col_next = col_reg + 3'd1;
            end
        end
    end

    always_comb begin
        calc_page = (state_reg == S_GLYPH) ? gpage[2:0] : cmd_reg.page;
        calc_col  = (state_reg == S_GLYPH) ? gx : cmd_reg.px;
        calc_addr = ADDR_W'(12'(calc_page) * 12'(geom.width) + 12'(calc_col));
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = calc_addr;
        ram_wdata = '0;
        q_pop     = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = idx_reg[ADDR_W-1:0];
            end
            S_IDLE: begin
                q_pop = q_valid;
            end
            S_FILL: begin
                ram_we    = (idx_reg != fill_cnt);
                ram_addr  = idx_reg[ADDR_W-1:0];
                ram_wdata = cmd_reg.pattern;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_addr  = addr_reg;
                ram_wdata = cmd_reg.on ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            col_reg     <= '0;
            slot_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // in S_DONE the result register is reloaded below instead
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CNT_W'(STORE_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (q_valid) begin
                        cmd_reg        <= q_cmd;
                        res_status_reg <= (q_cmd.kind == KIND_BAD);
                        res_data_reg   <= '0;
                        col_reg        <= '0;
                        slot_reg       <= 1'b0;
                        idx_reg        <= '0;
                        case (q_cmd.kind)
                            KIND_PIXEL: state_reg <= S_PIXEL;
                            KIND_CHAR:  state_reg <= S_GLYPH;
                            KIND_FILL:  state_reg <= S_FILL;
                            KIND_READ:  state_reg <= S_READ_ADDR;
                            default:    state_reg <= S_DONE;
                        endcase
                    end
                end
                S_PIXEL: begin
                    addr_reg  <= calc_addr;
                    mask_reg  <= pix_mask;
                    state_reg <= S_WRITE;
                end
                S_READ_ADDR: begin
                    state_reg <= S_READ_DATA;
                end
                S_READ_DATA: begin
                    res_data_reg <= ram_rdata;
                    state_reg    <= S_DONE;
                end
                S_GLYPH: begin
                    if (gskip) begin
                        state_reg <= adv_state;
                        col_reg   <= col_next;
                        slot_reg  <= slot_next;
                    end else begin
                        addr_reg  <= calc_addr;
                        mask_reg  <= gmask;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (cmd_reg.kind == KIND_CHAR) begin
                        state_reg <= adv_state;
                        col_reg   <= col_next;
                        slot_reg  <= slot_next;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_FILL: begin
                    if (idx_reg == fill_cnt) begin
                        state_reg <= S_DONE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= res_status_reg;
                        m_read_data_reg <= res_data_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/page_framebuffer_text_renderer_unit.sv */
// Top level of the page framebuffer text renderer: config registers, front end, queue, back end, store.
//
// Monochrome framebuffer kept in pages of 8 vertical pixels per byte, byte address
// page * width + column, in a single-port RAM of MAX_COLUMNS * MAX_PAGES bytes.
// Every input beat (draw pixel, draw 5x7 character, fill, read byte) yields exactly one
// result beat carrying a status bit and the read byte. A front end checks bounds and
// looks up the glyph, then parks the command in a two-entry queue, so until the queue is
// full the input side keeps taking beats while the back end works and while a result
// waits on m_ready. Cost per item is set by the single RAM port, where a pixel update is
// a read then a write; a rejected pixel or read, or a character code outside the font
// range, goes straight to the result. A character reads and writes each byte it touches
// (up to 10 bytes, five columns over two pages), and a fill writes width * pages bytes.
// After reset the back end zeroes all MAX_COLUMNS * MAX_PAGES bytes of the store (1024 at
// the defaults), one byte a cycle; s_ready stays low until that pass is over, while
// configuration writes are taken at any time. Register 0 is the panel width (clamped to
// MAX_COLUMNS), register 1 selects MAX_PAGES pages (8 pages, 64 rows, at the defaults)
// or 4 pages (32 rows). Change them only while the block is idle.
module page_framebuffer_text_renderer_unit #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_PAGES   = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    // command beats
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_pos_x,
    input  logic [7:0] s_pos_y,
    input  logic [2:0] s_read_page,
    input  logic [7:0] s_char_code,
    input  logic       s_pixel_on,
    input  logic [7:0] s_fill_pattern,
    // result beats
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_status,
    output logic [7:0] m_read_data
);
    import pfb_pkg::*;

    localparam int STORE_DEPTH = MAX_COLUMNS * MAX_PAGES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int CMD_W       = $bits(cmd_t);

    localparam logic [7:0] REG_PANEL_WIDTH = 8'd0;
    localparam logic [7:0] REG_TALL_PANEL  = 8'd1;

    logic [7:0]        panel_width_reg;
    logic              tall_panel_reg;
    geom_t             geom;

    logic              clear_busy;
    logic              push, queue_full, q_valid, q_pop;
    cmd_t              push_cmd, q_cmd;
    logic [CMD_W-1:0]  q_head;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;

    // --- configuration registers ---
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            panel_width_reg <= 8'd128;
            tall_panel_reg  <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PANEL_WIDTH: panel_width_reg <= cfg_data;
                REG_TALL_PANEL:  tall_panel_reg  <= cfg_data[0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // effective geometry, clamped to the built store
    always_comb begin
        geom.width = ({1'b0, panel_width_reg} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS)
                                                              : {1'b0, panel_width_reg};
        geom.pages = tall_panel_reg ? 4'(MAX_PAGES) : 4'd4;
    end

    // --- front end ---
    pfb_front u_front (
        .clear_busy     (clear_busy),
        .geom           (geom),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_read_page    (s_read_page),
        .s_char_code    (s_char_code),
        .s_pixel_on     (s_pixel_on),
        .s_fill_pattern (s_fill_pattern),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // --- command queue ---
    pfb_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_cmd),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    assign q_cmd = cmd_t'(q_head);

    // --- back end ---
    pfb_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .geom        (geom),
        .clear_busy  (clear_busy),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr),
        .ram_wdata   (ram_wdata),
        .ram_rdata   (ram_rdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_read_data (m_read_data)
    );

    // --- frame store ---
    pfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // --- assertions ---
    // no command beat gets in while the store is being zeroed
    assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !(s_valid && s_ready))
        else $error("command accepted during store clear");

    // a rejected pixel or read never carries data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_read_data == 8'd0))
        else $error("bad-parameter result with nonzero data");

    // the clearing pass starts right out of reset
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> clear_busy)
        else $error("store clear not running after reset");

endmodule
